[hdl/rhsl_pkg.sv]
// shared types and widths for the rgb to hsl converter
// no dependencies
package rhsl_pkg;

  localparam int QW   = 17;
  localparam int SD_W = 9;
  localparam int HD_W = 12;

  typedef struct packed {
    logic [15:0] light;
    logic [7:0]  alpha;
    logic        grey;
  } side_t;

  typedef struct packed {
    logic [7:0]  rng;
    logic [8:0]  den;
    logic [10:0] num;
    side_t       side;
  } div_req_t;

endpackage

[hdl/rhsl_div.sv]
// pipelined restoring divider, one quotient bit per stage for saturation and hue
// depends on rhsl_pkg
module rhsl_div import rhsl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_valid,
  input  div_req_t    req,
  output logic        req_go,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [15:0] res_hue,
  output logic [15:0] res_sat,
  output side_t       res_side
);

  logic            v_r  [QW];
  logic [SD_W-1:0] rs_r [QW];
  logic [SD_W-1:0] ds_r [QW];
  logic [QW-1:0]   ls_r [QW];
  logic [QW-1:0]   qs_r [QW];
  logic [HD_W-1:0] rh_r [QW];
  logic [HD_W-1:0] dh_r [QW];
  logic [QW-1:0]   lh_r [QW];
  logic [QW-1:0]   qh_r [QW];
  side_t           sd_r [QW];
  logic            go   [QW];

  logic [24:0] sat_n;
  assign sat_n = {req.rng, 17'b0} - 25'({req.rng, 1'b0}) + 25'(req.den);

  for (genvar i = 0; i < QW; i++) begin : g_stg
    logic            sv;
    logic [SD_W-1:0] srs, sds;
    logic [QW-1:0]   sls, sqs, slh, sqh;
    logic [HD_W-1:0] srh, sdh;
    side_t           ssd;
    logic [SD_W:0]   ts;
    logic [HD_W:0]   th;
    logic            qbs, qbh;

    if (i == 0) begin : g_first
      assign sv  = req_valid;
      assign srs = SD_W'(sat_n[24:17]);
      assign sls = sat_n[16:0];
      assign sds = SD_W'({req.den, 1'b0});
      assign sqs = '0;
      assign srh = HD_W'(req.num);
      assign slh = QW'(11'(req.rng) * 11'd6);
      assign sdh = HD_W'(12'(req.rng) * 12'd12);
      assign sqh = '0;
      assign ssd = req.side;
    end else begin : g_next
      assign sv  = v_r[i-1];
      assign srs = rs_r[i-1];
      assign sls = ls_r[i-1];
      assign sds = ds_r[i-1];
      assign sqs = qs_r[i-1];
      assign srh = rh_r[i-1];
      assign slh = lh_r[i-1];
      assign sdh = dh_r[i-1];
      assign sqh = qh_r[i-1];
      assign ssd = sd_r[i-1];
    end

    if (i == QW - 1) begin : g_last
      assign go[i] = !v_r[i] || !res_stall;
    end else begin : g_mid
      assign go[i] = !v_r[i] || go[i+1];
    end

    assign ts  = {srs, sls[QW-1]};
    assign th  = {srh, slh[QW-1]};
    assign qbs = (ts >= {1'b0, sds});
    assign qbh = (th >= {1'b0, sdh});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (go[i]) begin
        v_r[i] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (go[i]) begin
        rs_r[i] <= qbs ? SD_W'(ts - {1'b0, sds}) : SD_W'(ts);
        ls_r[i] <= {sls[QW-2:0], 1'b0};
        ds_r[i] <= sds;
        qs_r[i] <= {sqs[QW-2:0], qbs};
        rh_r[i] <= qbh ? HD_W'(th - {1'b0, sdh}) : HD_W'(th);
        lh_r[i] <= {slh[QW-2:0], 1'b0};
        dh_r[i] <= sdh;
        qh_r[i] <= {sqh[QW-2:0], qbh};
        sd_r[i] <= ssd;
      end
    end
  end

  assign req_go    = go[0];
  assign res_valid = v_r[QW-1];
  assign res_side  = sd_r[QW-1];
  assign res_hue   = sd_r[QW-1].grey ? 16'd0 : qh_r[QW-1][15:0];
  assign res_sat   = sd_r[QW-1].grey ? 16'd0 : qs_r[QW-1][15:0];

endmodule

[hdl/rgb_to_hsl_converter_core.sv]
// top level of the rgb to hsl converter: channel sort, hue/saturation setup, divider
// depends on rhsl_pkg and rhsl_div
//
// input channel: in_valid / in_stall with in_red, in_green, in_blue, in_alpha
// result channel: out_valid / out_stall with out_hue, out_saturation,
//   out_lightness, out_alpha_out
// an item is taken on a clock edge where valid is high and stall is low
// one result per item, in order
// pipeline: 19 register stages (two setup stages, then one stage per quotient
//   bit of the 17-bit divider); out_valid is the valid bit of the last stage
// throughput: one item per cycle while out_stall is low; every stage holds
//   its own valid bit
// when out_stall holds, items pack into empty stages behind the output;
//   in_stall rises only once every stage holds an item
// reset (rst_n low, synchronous) empties the pipeline; no result is pending
// after it
module rgb_to_hsl_converter_core import rhsl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_hue,
  output logic [15:0] out_saturation,
  output logic [15:0] out_lightness,
  output logic [7:0]  out_alpha_out
);

  localparam logic [2:0] MUL_RED   = 3'd0;
  localparam logic [2:0] MUL_GREEN = 3'd2;
  localparam logic [2:0] MUL_BLUE  = 3'd4;
  localparam logic [2:0] MUL_WRAP  = 3'd6;

  // stage 1: max, min, sector
  logic              s1_v_r;
  logic [7:0]        s1_mx_r, s1_mn_r, s1_a_r;
  logic [2:0]        s1_k_r;
  logic signed [8:0] s1_d_r;
  logic              s1_go, s2_go, div_go;

  logic [7:0]        mx_nxt, mn_nxt;
  logic [2:0]        k_nxt;
  logic signed [8:0] d_nxt;

  always_comb begin
    mx_nxt = in_red;
    mn_nxt = in_red;
    if (in_green > mx_nxt) mx_nxt = in_green;
    if (in_blue > mx_nxt) mx_nxt = in_blue;
    if (in_green < mn_nxt) mn_nxt = in_green;
    if (in_blue < mn_nxt) mn_nxt = in_blue;
    if (in_red >= in_green && in_red >= in_blue) begin
      k_nxt = MUL_RED;
      d_nxt = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
    end else if (in_green >= in_blue) begin
      k_nxt = MUL_GREEN;
      d_nxt = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
    end else begin
      k_nxt = MUL_BLUE;
      d_nxt = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
    end
  end

  assign s1_go    = !s1_v_r || s2_go;
  assign in_stall = !s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_go) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s1_mx_r <= mx_nxt;
      s1_mn_r <= mn_nxt;
      s1_k_r  <= k_nxt;
      s1_d_r  <= d_nxt;
      s1_a_r  <= in_alpha;
    end
  end

  // stage 2: range, sum, lightness, hue numerator, saturation denominator
  logic        s2_v_r;
  div_req_t    s2_req_r;
  div_req_t    req_nxt;
  logic [7:0]  rng;
  logic [8:0]  sum;
  logic [2:0]  mul;
  logic [17:0] l257;

  always_comb begin
    rng  = s1_mx_r - s1_mn_r;
    sum  = 9'(s1_mx_r) + 9'(s1_mn_r);
    mul  = (s1_k_r == MUL_RED && s1_d_r < 0) ? MUL_WRAP : s1_k_r;
    l257 = {1'b0, sum, 8'b0} + 18'(sum) + 18'd1;
    req_nxt.rng        = rng;
    req_nxt.den        = (sum < 9'd255) ? sum : 9'(10'd510 - 10'(sum));
    req_nxt.num        = 11'(11'(mul) * 11'(rng) + 11'(s1_d_r));
    req_nxt.side.light = l257[16:1];
    req_nxt.side.alpha = s1_a_r;
    req_nxt.side.grey  = (rng == 8'd0);
  end

  assign s2_go = !s2_v_r || div_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_go) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      s2_req_r <= req_nxt;
    end
  end

  side_t res_side;

  rhsl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (s2_v_r),
    .req       (s2_req_r),
    .req_go    (div_go),
    .res_valid (out_valid),
    .res_stall (out_stall),
    .res_hue   (out_hue),
    .res_sat   (out_saturation),
    .res_side  (res_side)
  );

  assign out_lightness = res_side.light;
  assign out_alpha_out = res_side.alpha;

  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturation == 16'd0) |-> (out_hue == 16'd0))
    else $error("grey item with nonzero hue");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && s1_v_r && s2_v_r))
    else $error("input stalled with room in the pipeline");

  a_grey_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && res_side.grey) |-> (out_saturation == 16'd0))
    else $error("grey item with nonzero saturation");

endmodule
